/* hdl/vbrc_pkg.sv */
// ============================================================================
// vbrc_pkg
// Shared constants, command codes, controller/datapath interface types and a
// popcount helper for the VLAN bitmap range counter.
// ============================================================================
package vbrc_pkg;

    // Map geometry. IDs are 12 bits wide, so the map covers every ID.
    localparam int ID_COUNT  = 4096;
    localparam int ID_W      = 12;
    localparam int WORD_BITS = 64;
    localparam int MAP_WORDS = ID_COUNT / WORD_BITS;
    localparam int WORD_AW   = $clog2(MAP_WORDS);
    localparam int OFF_W     = $clog2(WORD_BITS);
    localparam int POP_W     = $clog2(WORD_BITS) + 1;
    localparam int CNT_W     = 13;
    localparam int CMD_W     = 2;

    // Widths of the request (slave-side) and result (master-side) tdata buses.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    // Command codes carried in s_tuser.
    localparam logic [CMD_W-1:0] CMD_TEST  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COUNT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RSVD  = 2'd3;

    // Controller to datapath commands.
    typedef struct packed {
        logic               req_load;   // capture the accepted request
        logic               rd_en;      // read one map word
        logic [WORD_AW-1:0] rd_addr;    // word address of that read
        logic               cnt_tag;    // the read feeds the range count
        logic               step_en;    // evaluate a test or write back a set
        logic               out_load;   // move the result into the output register
    } vbrc_ctl_t;

    // Datapath to controller status.
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;        // command of the captured request
        logic [WORD_AW-1:0] first_word; // first word to read
        logic [WORD_AW-1:0] last_word;  // last word of a count range
        logic               empty_range;
        logic               pipe_busy;  // count reads still in flight
        logic               out_free;   // output register can take a result
    } vbrc_sts_t;

    // Number of ones in one map word.
    function automatic logic [POP_W-1:0] popcount_word(input logic [WORD_BITS-1:0] w);
        logic [POP_W-1:0] s;
        s = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            s = s + POP_W'(w[i]);
        end
        return s;
    endfunction

endpackage

/* hdl/vbrc_ctrl.sv */
// ============================================================================
// vbrc_ctrl
// Sequencer for one request at a time: dispatch, word reads, drain and
// hand-off of the result.
// ============================================================================
module vbrc_ctrl
    import vbrc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  vbrc_sts_t sts,
    output vbrc_ctl_t ctl
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_ISSUE    = 3'd2;
    localparam logic [2:0] ST_STEP     = 3'd3;
    localparam logic [2:0] ST_DRAIN    = 3'd4;
    localparam logic [2:0] ST_FINISH   = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [WORD_AW-1:0] addr_reg, addr_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        ctl          = '0;
        ctl.rd_addr  = addr_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ctl.req_load = 1'b1;
                    state_next   = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (sts.cmd)
                    CMD_TEST, CMD_SET: begin
                        ctl.rd_en   = 1'b1;
                        ctl.rd_addr = sts.first_word;
                        state_next  = ST_STEP;
                    end
                    CMD_COUNT: begin
                        addr_next  = sts.first_word;
                        state_next = sts.empty_range ? ST_FINISH : ST_ISSUE;
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_ISSUE: begin
                ctl.rd_en   = 1'b1;
                ctl.cnt_tag = 1'b1;
                addr_next   = addr_reg + 1'b1;
                if (addr_reg == sts.last_word) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_STEP: begin
                ctl.step_en = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_DRAIN: begin
                if (!sts.pipe_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/vbrc_datapath.sv */
// ============================================================================
// vbrc_datapath
// Request registers, the bitmap memory with per-row valid bits, the masked
// popcount pipeline with its accumulator, and the output register.
// ============================================================================
module vbrc_datapath
    import vbrc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [CMD_W-1:0]     s_tuser,
    input  vbrc_ctl_t            ctl,
    output vbrc_sts_t            sts,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    // Captured request.
    logic [CMD_W-1:0] cmd_reg;
    logic [ID_W-1:0]  id_reg;
    logic             mark_reg;
    logic [ID_W-1:0]  lo_reg;
    logic [ID_W-1:0]  hi_reg;

    // Bitmap storage. A row whose valid bit is clear reads as all zero.
    logic [WORD_BITS-1:0] mem [0:MAP_WORDS-1];
    logic [MAP_WORDS-1:0] row_vld_reg;
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 rrow_vld_reg;

    // Count pipeline.
    logic                 a_vld_reg;
    logic [WORD_AW-1:0]   a_addr_reg;
    logic                 b_vld_reg;
    logic [WORD_BITS-1:0] masked_reg;
    logic [CNT_W-1:0]     acc_reg;
    logic                 res_bit_reg;

    // Output register.
    logic                 out_vld_reg;
    logic                 out_is_valid_reg;
    logic [CNT_W-1:0]     out_count_reg;

    logic [WORD_BITS-1:0] word_q;
    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] new_word;
    logic [WORD_BITS-1:0] range_mask;
    logic [OFF_W-1:0]     lo_off_eff;
    logic [OFF_W-1:0]     hi_off_eff;
    logic [OFF_W-1:0]     id_off;
    logic [WORD_AW-1:0]   id_word;
    logic                 wr_en;

    assign id_off  = id_reg[OFF_W-1:0];
    assign id_word = id_reg[ID_W-1:OFF_W];

    always_ff @(posedge aclk) begin
        if (ctl.req_load) begin
            cmd_reg  <= s_tuser;
            id_reg   <= s_tdata[11:0];
            mark_reg <= s_tdata[12];
            lo_reg   <= s_tdata[24:13];
            hi_reg   <= s_tdata[36:25];
        end
    end

    // Word 0 bit 63 holds ID 0, so reversing the word puts ID offset i at bit i.
    assign word_q = rrow_vld_reg ? rdata_reg : '0;
    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            free_bits[i] = ~word_q[WORD_BITS-1-i];
        end
    end

    always_comb begin
        new_word = word_q;
        new_word[OFF_W'(WORD_BITS-1) - id_off] = mark_reg;
    end

    assign wr_en = ctl.step_en && (cmd_reg == CMD_SET);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[id_word] <= new_word;
        end
        if (ctl.rd_en) begin
            rdata_reg    <= mem[ctl.rd_addr];
            rrow_vld_reg <= row_vld_reg[ctl.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
        end else if (wr_en) begin
            row_vld_reg[id_word] <= 1'b1;
        end
    end

    // Bits of the range inside the word just read: the end words are cut
    // at the range offsets, words in between count whole.
    assign lo_off_eff = (a_addr_reg == lo_reg[ID_W-1:OFF_W]) ? lo_reg[OFF_W-1:0] : '0;
    assign hi_off_eff = (a_addr_reg == hi_reg[ID_W-1:OFF_W]) ? hi_reg[OFF_W-1:0] : '1;
    assign range_mask = ({WORD_BITS{1'b1}} << lo_off_eff)
                      & ({WORD_BITS{1'b1}} >> (OFF_W'(WORD_BITS-1) - hi_off_eff));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= ctl.rd_en && ctl.cnt_tag;
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_addr_reg <= ctl.rd_addr;
        masked_reg <= free_bits & range_mask;
        if (ctl.req_load) begin
            acc_reg     <= '0;
            res_bit_reg <= 1'b0;
        end else begin
            if (b_vld_reg) begin
                acc_reg <= acc_reg + CNT_W'(popcount_word(masked_reg));
            end
            if (ctl.step_en && (cmd_reg == CMD_TEST)) begin
                res_bit_reg <= free_bits[id_off];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (ctl.out_load) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            out_is_valid_reg <= (cmd_reg == CMD_TEST) && res_bit_reg;
            out_count_reg    <= (cmd_reg == CMD_COUNT) ? acc_reg : '0;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00, out_count_reg, out_is_valid_reg};

    assign sts.cmd         = cmd_reg;
    assign sts.first_word  = (cmd_reg == CMD_COUNT) ? lo_reg[ID_W-1:OFF_W] : id_word;
    assign sts.last_word   = hi_reg[ID_W-1:OFF_W];
    assign sts.empty_range = (lo_reg > hi_reg);
    assign sts.pipe_busy   = a_vld_reg || b_vld_reg;
    assign sts.out_free    = !out_vld_reg || m_tready;

endmodule

/* hdl/vlan_bitmap_range_counter_core.sv */
// ============================================================================
// vlan_bitmap_range_counter_core
// VLAN validity bitmap with single-ID test, single-ID mark and a range count
// of valid IDs.
// ============================================================================
//
//  Channel  Direction  Handshake          Payload
//  -------  ---------  -----------------  -------------------------------------
//  s_       in         s_tvalid/s_tready  tuser: cmd; tdata: vlan_id,
//                                         mark_invalid, range_low, range_high
//  m_       out        m_tvalid/m_tready  tdata: is_valid, valid_count
//
// Every request produces exactly one result. A test or a set goes from
// acceptance through one word read, one step that evaluates the bit or
// writes the word back, and the hand-off to the result register. A count
// of a range reads its map words through the single read port of the
// 64 x 64-bit map memory, which delivers one word per cycle into a masked
// popcount pipeline. An empty range (low above high) and the reserved
// command skip the reads and answer with zero fields.
// Reset is synchronous and active low. It clears the per-row valid bits, so
// every ID reads as valid right after reset without a clearing pass.
// The block works on one request at a time. A finished result sits in the
// output register while the next request is accepted and processed; only
// the hand-off of that next result waits for m_tready.
//
module vlan_bitmap_range_counter_core
    import vbrc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [11:0] vlan_id, [12] mark_invalid, [24:13] range_low, [36:25] range_high
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] cmd
    input  logic [CMD_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] is_valid, [13:1] valid_count
    output logic [M_TDATA_W-1:0] m_tdata
);

    vbrc_ctl_t ctl;
    vbrc_sts_t sts;

    // The controller sequences each request; of the datapath it sees only the status bundle.
    vbrc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // The datapath holds the map, the count pipeline and the result register.
    vbrc_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .ctl      (ctl),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Once a request is taken, no second one is taken in the next cycle.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in progress");

    // A count never exceeds the size of the map.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[13:1] <= CNT_W'(ID_COUNT)))
        else $error("valid_count beyond map size");

    // A result carries at most one meaningful field.
    a_one_field: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && (m_tdata[13:1] != '0)))
        else $error("both result fields set");

    // The count pipeline is drained before a result is handed over.
    a_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |-> !sts.pipe_busy)
        else $error("result loaded with count reads in flight");

endmodule

/* tb/sv/vlan_bitmap_range_counter_core_test.sv */
// ============================================================================
// vlan_bitmap_range_counter_core_test
// Self-checking testbench for the VLAN validity bitmap with test, mark and
// range count requests. A local model of the 4096-bit map predicts every
// result at the moment its request is accepted. Each result that leaves the
// block is compared field by field with the oldest prediction. The stimulus
// is a short directed part, a long output stall that fills the block, and
// random traffic, mostly mark/test/count sequences on local ID regions.
// ============================================================================
module vlan_bitmap_range_counter_core_test;
    import vbrc_pkg::*;

    localparam int RANDOM_REQUESTS = 530;
    localparam int HOLD_OFF_CYCLES = 400;
    // No handshake on either side for this many cycles ends the run.
    localparam int STALL_LIMIT     = 4000;
    // Longest request is a full-range count.
    localparam int DRAIN_CYCLES    = 100;

    typedef struct packed {
        logic             is_valid;
        logic [CNT_W-1:0] valid_count;
    } vlan_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [11:0] vlan_id, [12] mark_invalid, [24:13] range_low, [36:25] range_high
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // [1:0] cmd
    logic [CMD_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [0] is_valid, [13:1] valid_count
    logic [M_TDATA_W-1:0] m_tdata;

    // Local copy of the map: ID n sits in word n/64 at bit 63-(n%64).
    logic [WORD_BITS-1:0] vlan_map [MAP_WORDS];
    vlan_result_t         pending_results [$];

    int unsigned error_count    = 0;
    int unsigned requests_sent  = 0;
    int unsigned burst_left     = 0;
    int unsigned idle_cycles    = 0;
    bit          gaps_enabled   = 1'b1;
    bit          hold_off_request = 1'b0;
    bit          hold_off_active  = 1'b0;

    vlan_bitmap_range_counter_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Applies one accepted request to the local map and returns its result.
    function automatic vlan_result_t apply_vlan_request(
        input logic [CMD_W-1:0] cmd,
        input logic [ID_W-1:0]  id,
        input logic             inval,
        input logic [ID_W-1:0]  lo,
        input logic [ID_W-1:0]  hi
    );
        vlan_result_t r;
        int           n;
        r = '0;
        case (cmd)
            CMD_TEST: begin
                if (int'(id) < ID_COUNT) begin
                    r.is_valid = ~vlan_map[id / WORD_BITS][WORD_BITS - 1 - id % WORD_BITS];
                end
            end
            CMD_SET: begin
                if (int'(id) < ID_COUNT) begin
                    vlan_map[id / WORD_BITS][WORD_BITS - 1 - id % WORD_BITS] = inval;
                end
            end
            CMD_COUNT: begin
                // An empty range (low above high) leaves the count at zero.
                for (n = int'(lo); n <= int'(hi) && n < ID_COUNT; n++) begin
                    if (!vlan_map[n / WORD_BITS][WORD_BITS - 1 - n % WORD_BITS]) begin
                        r.valid_count++;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        return ID_W'($urandom());
    endfunction

    // Random ID in [base, base + span], clipped at the top of the map.
    function automatic logic [ID_W-1:0] region_id(int unsigned base, int unsigned span);
        int unsigned n;
        n = base + $urandom_range(0, span);
        if (n > ID_COUNT - 1) begin
            n = ID_COUNT - 1;
        end
        return ID_W'(n);
    endfunction

    // Offers one request, waiting for acceptance. Inputs change on the
    // falling edge; while gaps are enabled, the sender may idle between bursts of random length.
    task automatic send_request(
        input logic [CMD_W-1:0] cmd,
        input logic [ID_W-1:0]  id,
        input logic             inval,
        input logic [ID_W-1:0]  lo,
        input logic [ID_W-1:0]  hi
    );
        int unsigned gap;
        @(negedge aclk);
        if (gaps_enabled && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 16);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        if (burst_left != 0) begin
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_TDATA_W - 37){1'b0}}, hi, lo, inval, id};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_vlan_request(cmd, id, inval, lo, hi));
        if (cmd != CMD_RSVD) begin
            requests_sent++;
        end
    endtask

    // Must follow the last send of a phase directly, so no stale request
    // is seen as a new one.
    task automatic release_sender();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_until_drained();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Edges of every field, every command and the corner cases: words at
    // both ends of the map, a word boundary, empty and single-ID ranges,
    // a full-range count and the reserved command.
    task automatic test_directed_edges();
        send_request(CMD_TEST,  12'd0,    1'b0, 12'hFFF, 12'hFFF);
        send_request(CMD_TEST,  12'd4095, 1'b1, 12'd0,   12'd0);
        send_request(CMD_COUNT, 12'hFFF,  1'b1, 12'd0,   12'd4095);
        send_request(CMD_SET,   12'd0,    1'b1, 12'd0,   12'd0);
        send_request(CMD_SET,   12'd4095, 1'b1, 12'hFFF, 12'hFFF);
        send_request(CMD_SET,   12'd63,   1'b1, 12'd5,   12'd9);
        send_request(CMD_SET,   12'd64,   1'b1, 12'd0,   12'd0);
        send_request(CMD_TEST,  12'd0,    1'b0, 12'd0,   12'd0);
        send_request(CMD_TEST,  12'd63,   1'b0, 12'd0,   12'd0);
        send_request(CMD_COUNT, 12'd0,    1'b0, 12'd0,   12'd4095);
        send_request(CMD_COUNT, 12'd0,    1'b0, 12'd60,  12'd70);
        send_request(CMD_COUNT, 12'd0,    1'b0, 12'd100, 12'd99);
        send_request(CMD_COUNT, 12'd0,    1'b0, 12'd4095, 12'd0);
        send_request(CMD_COUNT, 12'd0,    1'b0, 12'd64,  12'd64);
        send_request(CMD_COUNT, 12'd0,    1'b0, 12'd4095, 12'd4095);
        send_request(CMD_COUNT, 12'd0,    1'b0, 12'd0,   12'd0);
        send_request(CMD_SET,   12'd63,   1'b0, 12'd0,   12'd0);
        send_request(CMD_TEST,  12'd63,   1'b0, 12'd0,   12'd0);
        send_request(CMD_RSVD,  12'hFFF,  1'b1, 12'hFFF, 12'hFFF);
        send_request(CMD_TEST,  12'd4095, 1'b1, 12'hFFF, 12'hFFF);
        send_request(CMD_SET,   12'd4095, 1'b1, 12'd0,   12'd0);
        send_request(CMD_COUNT, 12'd0,    1'b0, 12'd4032, 12'd4095);
        release_sender();
        wait_until_drained();
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so the output register fills and the block stalls its input.
    task automatic test_output_backpressure();
        int i;
        hold_off_request = 1'b1;
        wait (hold_off_active);
        gaps_enabled = 1'b0;
        for (i = 0; i < 16; i++) begin
            case (i % 3)
                0:       send_request(CMD_SET, rand_id(), 1'($urandom()), rand_id(), rand_id());
                1:       send_request(CMD_TEST, rand_id(), 1'($urandom()), rand_id(), rand_id());
                default: send_request(CMD_COUNT, rand_id(), 1'($urandom()), 12'd0, 12'd200);
            endcase
        end
        gaps_enabled = 1'b1;
        release_sender();
        wait_until_drained();
    endtask

    // Mostly mark/test/count sequences on one region of IDs, so the counts
    // see mixed maps; the rest is wide counts, random-range counts and fully random requests.
    task automatic test_random_traffic();
        int unsigned     first;
        int unsigned     base;
        int unsigned     span;
        int unsigned     marks;
        int unsigned     tests;
        int unsigned     i;
        logic [ID_W-1:0] lo;
        logic [ID_W-1:0] hi;
        logic [ID_W-1:0] t;
        first = requests_sent;
        while (requests_sent - first < RANDOM_REQUESTS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    base  = $urandom_range(0, ID_COUNT - 1);
                    span  = ($urandom_range(0, 7) == 0) ? $urandom_range(200, ID_COUNT - 1)
                                                        : $urandom_range(1, 150);
                    marks = $urandom_range(2, 8);
                    tests = $urandom_range(1, 3);
                    for (i = 0; i < marks; i++) begin
                        send_request(CMD_SET, region_id(base, span), $urandom_range(0, 9) < 7,
                                     rand_id(), rand_id());
                    end
                    for (i = 0; i < tests; i++) begin
                        send_request(CMD_TEST, region_id(base, span), 1'($urandom()),
                                     rand_id(), rand_id());
                    end
                    lo = region_id(base, span);
                    hi = region_id(base, span);
                    // Keep most ranges ordered; the rest stay as drawn.
                    if (lo > hi && $urandom_range(0, 5) != 0) begin
                        t  = lo;
                        lo = hi;
                        hi = t;
                    end
                    send_request(CMD_COUNT, rand_id(), 1'($urandom()), lo, hi);
                end
                6, 7: begin
                    send_request(CMD_W'($urandom_range(0, 3)), rand_id(),
                                 1'($urandom()), rand_id(), rand_id());
                end
                8: begin
                    send_request(CMD_COUNT, rand_id(), 1'($urandom()),
                                 ID_W'($urandom_range(0, 63)),
                                 ID_W'($urandom_range(ID_COUNT - 64, ID_COUNT - 1)));
                end
                default: begin
                    send_request(CMD_COUNT, rand_id(), 1'($urandom()), rand_id(), rand_id());
                end
            endcase
        end
        release_sender();
        wait_until_drained();
    endtask

    // Receiver: a ready pattern that changes mode at random intervals,
    // plus one long hold-off when a test asks for it.
    initial begin : result_receiver
        int unsigned mode_left;
        int unsigned mode;
        mode_left = 0;
        mode      = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_request) begin
                m_tready <= 1'b0;
                hold_off_active = 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_request = 1'b0;
                hold_off_active  = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom());
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (mode_left % 16) < 8;
                endcase
            end
        end
    end

    // Every accepted result is checked against the oldest prediction.
    always @(posedge aclk) begin : result_checker
        vlan_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: is_valid %0d, valid_count %0d",
                       m_tdata[0], m_tdata[13:1]);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.is_valid) begin
                    $error("is_valid: expected %0d, actual %0d", want.is_valid, m_tdata[0]);
                    error_count++;
                end
                if (m_tdata[13:1] !== want.valid_count) begin
                    $error("valid_count: expected %0d, actual %0d",
                           want.valid_count, m_tdata[13:1]);
                    error_count++;
                end
            end
        end
    end

    // Ends a hung run: counts cycles with no handshake on either side.
    always @(posedge aclk) begin : stall_watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("** vlan_bitmap_range_counter_core: FAILED **");
            $finish;
        end
    end

    initial begin : test_sequence
        for (int w = 0; w < MAP_WORDS; w++) begin
            vlan_map[w] = '0;
        end
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_edges();
        test_output_backpressure();
        test_random_traffic();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("** vlan_bitmap_range_counter_core: PASSED **");
        end else begin
            $display("** vlan_bitmap_range_counter_core: FAILED **");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/vbrc_pkg.sv
hdl/vbrc_ctrl.sv
hdl/vbrc_datapath.sv
hdl/vlan_bitmap_range_counter_core.sv
tb/sv/vlan_bitmap_range_counter_core_test.sv
